// File: hw/rtl/dot_matrix_text_quad_generator_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the dot-matrix text quad generator
// ----------------------------------------------------------------------------
`ifndef DOT_MATRIX_TEXT_QUAD_GENERATOR_CORE_MACROS_SVH
`define DOT_MATRIX_TEXT_QUAD_GENERATOR_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define DMTQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define DMTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/dmtq_pkg.sv
// ----------------------------------------------------------------------------
// dmtq_pkg
// types, constants and helpers shared by the text quad generator
// ----------------------------------------------------------------------------
package dmtq_pkg;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 8;
    localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
    localparam int COL_W      = $clog2(GLYPH_COLS);

    localparam logic [7:0] CODE_LF = 8'd10;
    localparam logic [7:0] CODE_CR = 8'd13;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_CHAR  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_GAP_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_GAP_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_GAP_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_GAP_Y = 3'd5;
    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic               command;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [31:0]        text_color;
        logic [7:0]         char_code;
        logic [39:0]        glyph_bits;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic [31:0]        dot_color;
        logic               last_dot;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic ld_start;
        logic line_break;
        logic ld_char;
        logic step;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_is_char;
        logic in_is_break;
        logic out_free;
        logic rest_zero;
    } t_dp_sts;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > 18'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/dmtq_ctrl.sv
// ----------------------------------------------------------------------------
// dmtq_ctrl
// sequencer: takes transactions and steps the datapath over the glyph bits
// ----------------------------------------------------------------------------
`include "dot_matrix_text_quad_generator_core_macros.svh"

module dmtq_ctrl
    import dmtq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic       r_state;
    logic       n_state;
    logic       accept;
    logic [3:0] cmd_vec;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.ld_start   = accept && !i_sts.in_is_char;
        o_cmd.line_break = accept && i_sts.in_is_char && i_sts.in_is_break;
        o_cmd.ld_char    = accept && i_sts.in_is_char && !i_sts.in_is_break;
        o_cmd.step       = (r_state == ST_SCAN) && i_sts.out_free;
        o_cmd.finish     = o_cmd.step && i_sts.rest_zero;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.ld_char) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (o_cmd.finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign cmd_vec = {o_cmd.ld_start, o_cmd.line_break, o_cmd.ld_char, o_cmd.step};

    `DMTQ_ASSERT(a_step_only_scan, i_clk, i_rst_n, o_cmd.step |-> r_state == ST_SCAN, "step outside scan")
    `DMTQ_ASSERT(a_finish_idle, i_clk, i_rst_n, o_cmd.finish |=> r_state == ST_IDLE, "finish did not end scan")
    `DMTQ_ASSERT(a_cmd_excl, i_clk, i_rst_n, $onehot0(cmd_vec), "overlapping datapath commands")

endmodule

// File: hw/rtl/dmtq_datapath.sv
// ----------------------------------------------------------------------------
// dmtq_datapath
// config registers, pen state, glyph scan and output register
// ----------------------------------------------------------------------------
`include "dot_matrix_text_quad_generator_core_macros.svh"

module dmtq_datapath
    import dmtq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_in_item              i_in_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    logic [7:0] r_dot_w, r_dot_h, r_gap_x, r_gap_y, r_ggap_x, r_ggap_y;

    logic signed [15:0] r_pen_x, r_pen_y, r_line_x;
    logic [31:0]        r_color;

    logic [GLYPH_BITS-1:0] r_bits;
    logic [COL_W-1:0]      r_col;
    logic [10:0]           r_xoff;
    logic [11:0]           r_yoff;

    logic      r_out_valid;
    t_out_item r_out;

    logic [8:0]         cell_x, cell_y;
    logic [11:0]        pitch;
    logic [12:0]        line_adv;
    logic signed [17:0] x1, y1, x2, y2;
    logic signed [17:0] pen_x_adv, pen_y_adv;

    assign cell_x   = {1'b0, r_dot_w} + {1'b0, r_gap_x};
    assign cell_y   = {1'b0, r_dot_h} + {1'b0, r_gap_y};
    assign pitch    = {1'b0, cell_x, 2'b00} + {3'b000, cell_x} + {4'b0000, r_ggap_x};
    assign line_adv = {1'b0, cell_y, 3'b000} + {4'b0000, r_ggap_y, 1'b0};

    assign x1 = {{2{r_pen_x[15]}}, r_pen_x} + $signed({7'b0, r_xoff});
    assign y1 = {{2{r_pen_y[15]}}, r_pen_y} + $signed({6'b0, r_yoff});
    assign x2 = x1 + $signed({10'b0, r_dot_w});
    assign y2 = y1 + $signed({10'b0, r_dot_h});

    assign pen_x_adv = {{2{r_pen_x[15]}}, r_pen_x} + $signed({6'b0, pitch});
    assign pen_y_adv = {{2{r_pen_y[15]}}, r_pen_y} + $signed({5'b0, line_adv});

    assign o_sts.in_is_char  = (i_in_data.command == CMD_CHAR);
    assign o_sts.in_is_break = (i_in_data.char_code == CODE_LF) ||
                               (i_in_data.char_code == CODE_CR);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.rest_zero   = (r_bits[GLYPH_BITS-1:1] == '0);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_w  <= 8'd1;
            r_dot_h  <= 8'd1;
            r_gap_x  <= 8'd0;
            r_gap_y  <= 8'd0;
            r_ggap_x <= 8'd1;
            r_ggap_y <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DOT_WIDTH:   r_dot_w  <= i_cfg_wdata;
                REG_DOT_HEIGHT:  r_dot_h  <= i_cfg_wdata;
                REG_DOT_GAP_X:   r_gap_x  <= i_cfg_wdata;
                REG_DOT_GAP_Y:   r_gap_y  <= i_cfg_wdata;
                REG_GLYPH_GAP_X: r_ggap_x <= i_cfg_wdata;
                REG_GLYPH_GAP_Y: r_ggap_y <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pen state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x  <= '0;
            r_pen_y  <= '0;
            r_line_x <= '0;
            r_color  <= '0;
        end else if (i_cmd.ld_start) begin
            r_pen_x  <= i_in_data.start_x;
            r_pen_y  <= i_in_data.start_y;
            r_line_x <= i_in_data.start_x;
            r_color  <= i_in_data.text_color;
        end else if (i_cmd.line_break) begin
            r_pen_x <= r_line_x;
            r_pen_y <= sat16(pen_y_adv);
        end else if (i_cmd.finish) begin
            r_pen_x <= sat16(pen_x_adv);
        end
    end

    // glyph scan, one bit position per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_char) begin
            r_bits <= i_in_data.glyph_bits;
            r_col  <= '0;
            r_xoff <= '0;
            r_yoff <= '0;
        end else if (i_cmd.step) begin
            r_bits <= {1'b0, r_bits[GLYPH_BITS-1:1]};
            if (r_col == COL_W'(GLYPH_COLS - 1)) begin
                r_col  <= '0;
                r_xoff <= '0;
                r_yoff <= r_yoff + {3'b000, cell_y};
            end else begin
                r_col  <= r_col + COL_W'(1);
                r_xoff <= r_xoff + {2'b00, cell_x};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && r_bits[0]) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && r_bits[0]) begin
            r_out.left      <= sat16(x1);
            r_out.top       <= sat16(y1);
            r_out.right     <= sat16(x2);
            r_out.bottom    <= sat16(y2);
            r_out.dot_color <= r_color;
            r_out.last_dot  <= o_sts.rest_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `DMTQ_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |-> !i_cmd.step, "step while result stalled")

endmodule

// File: hw/rtl/dot_matrix_text_quad_generator_core.sv
// ----------------------------------------------------------------------------
// dot_matrix_text_quad_generator_core
// 5x8 dot-matrix text to rectangle generator
// ----------------------------------------------------------------------------
// A start transaction latches pen position, line start x and color on
// acceptance and produces nothing. A line feed or carriage return returns
// the pen to the line start and moves it down by eight dot cells plus twice
// the glyph y gap, also on acceptance. Any other character is scanned one
// glyph bit per cycle in row-major order while the output side is not
// stalled; each lit bit yields one rectangle with the last flag on the final
// one, and the scan stops right after the highest lit bit. The next
// transaction is taken once the scan of the current one ends; the final
// rectangle may still sit in the output register at that time. All
// coordinates saturate to signed 16 bits. Configuration must be written
// through the plain write port only while no character is in flight; the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module dot_matrix_text_quad_generator_core
    import dmtq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port, register index per list order
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input transaction channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    // rectangle output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    // command and status between sequencer and datapath
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: idle or scanning a glyph
    dmtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // datapath: config, pen, scan shift register, output register
    dmtq_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
